// ===== hw/rtl/bspe_pkg.sv =====
// Shared types, constants and helper functions of the sensor payload encoder.
package bspe_pkg;

    // Service-data framing bytes.
    localparam logic [7:0] HDR_UUID_LO   = 8'hD2;
    localparam logic [7:0] HDR_UUID_HI   = 8'hFC;
    localparam logic [7:0] HDR_DEV_INFO  = 8'h40;
    localparam logic [7:0] OBJ_BATTERY   = 8'h01;
    localparam logic [7:0] OBJ_TEMP      = 8'h02;
    localparam logic [7:0] OBJ_HUMIDITY  = 8'h03;
    localparam logic [7:0] OBJ_PRESSURE  = 8'h04;
    localparam logic [7:0] OBJ_VOLTAGE   = 8'h0C;

    // Byte positions within the long payload.
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_BATT     = 5'd4;
    localparam logic [POS_W-1:0] POS_VOLT_ID  = 5'd15;
    localparam logic [POS_W-1:0] POS_LAST     = 5'd17;

    // Battery curve end points and segment count.
    localparam logic [11:0] BATT_TOP_MV = 12'd3200;
    localparam logic [11:0] BATT_BOT_MV = 12'd2000;
    localparam int unsigned SEG_COUNT   = 10;
    localparam logic [6:0]  PCT_FULL    = 7'd100;

    // Every segment span is 50 mV times one of these factors.
    typedef enum logic [2:0] {
        DIV_1,
        DIV_2,
        DIV_3,
        DIV_4,
        DIV_8
    } t_div;

    // One segment of the battery curve.
    typedef struct packed {
        logic [11:0] hi_mv;
        logic [11:0] lo_mv;
        logic [6:0]  hi_pct;
        logic [3:0]  pct_span;
        logic [7:0]  half_span;
        t_div        div;
    } t_seg;

    // Converted values of one reading, as handed from front to back.
    typedef struct packed {
        logic        sensor_valid;
        logic [6:0]  batt;
        logic [11:0] mv;
        logic [15:0] temp;
        logic [15:0] hum;
        logic [23:0] pres;
    } t_rec;

    // Battery curve segments, highest voltage first.
    function automatic t_seg seg_entry(input logic [3:0] idx);
        t_seg s;
        s = '0;
        unique case (idx)
            4'd0: s = '{12'd3200, 12'd3050, 7'd100, 4'd5,  8'd75,  DIV_3};
            4'd1: s = '{12'd3050, 12'd2950, 7'd95,  4'd5,  8'd50,  DIV_2};
            4'd2: s = '{12'd2950, 12'd2900, 7'd90,  4'd10, 8'd25,  DIV_1};
            4'd3: s = '{12'd2900, 12'd2850, 7'd80,  4'd10, 8'd25,  DIV_1};
            4'd4: s = '{12'd2850, 12'd2800, 7'd70,  4'd10, 8'd25,  DIV_1};
            4'd5: s = '{12'd2800, 12'd2750, 7'd60,  4'd15, 8'd25,  DIV_1};
            4'd6: s = '{12'd2750, 12'd2700, 7'd45,  4'd15, 8'd25,  DIV_1};
            4'd7: s = '{12'd2700, 12'd2600, 7'd30,  4'd15, 8'd50,  DIV_2};
            4'd8: s = '{12'd2600, 12'd2400, 7'd15,  4'd10, 8'd100, DIV_4};
            4'd9: s = '{12'd2400, 12'd2000, 7'd5,   4'd5,  8'd200, DIV_8};
            default: s = '0;
        endcase
        return s;
    endfunction

    // Byte at a given payload position.
    function automatic logic [7:0] payload_at(input t_rec r, input logic [POS_W-1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        unique case (pos)
            5'd0:  b = HDR_UUID_LO;
            5'd1:  b = HDR_UUID_HI;
            5'd2:  b = HDR_DEV_INFO;
            5'd3:  b = OBJ_BATTERY;
            5'd4:  b = {1'b0, r.batt};
            5'd5:  b = OBJ_TEMP;
            5'd6:  b = r.temp[7:0];
            5'd7:  b = r.temp[15:8];
            5'd8:  b = OBJ_HUMIDITY;
            5'd9:  b = r.hum[7:0];
            5'd10: b = r.hum[15:8];
            5'd11: b = OBJ_PRESSURE;
            5'd12: b = r.pres[7:0];
            5'd13: b = r.pres[15:8];
            5'd14: b = r.pres[23:16];
            5'd15: b = OBJ_VOLTAGE;
            5'd16: b = r.mv[7:0];
            5'd17: b = {4'h0, r.mv[11:8]};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/bspe_front.sv =====
// Front part: accepts readings and converts them to payload values in three stages.
module bspe_front
    import bspe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic signed [12:0] i_supply_sample,
    input  logic               i_sensor_valid,
    input  logic signed [15:0] i_temperature_q8,
    input  logic        [14:0] i_humidity_q8,
    input  logic        [18:0] i_pressure_q8,
    output logic               o_wr_en,
    output t_rec               o_wr_rec,
    output logic [1:0]         o_inflight
);

    typedef enum logic [1:0] {
        SAT_NONE,
        SAT_FULL,
        SAT_ZERO
    } t_sat;

    // Stage A registers.
    logic        r_a_vld;
    logic        r_a_sens;
    logic [11:0] r_a_mv;
    logic        r_a_tneg;
    logic [14:0] r_a_tmag;
    logic [13:0] r_a_hum;
    logic [17:0] r_a_pres;

    // Stage B registers.
    logic        r_b_vld;
    logic        r_b_sens;
    logic [11:0] r_b_mv;
    logic [15:0] r_b_temp;
    logic [13:0] r_b_hum;
    logic [17:0] r_b_pres;
    logic [11:0] r_b_num;
    logic [6:0]  r_b_pct;
    t_div        r_b_div;
    t_sat        r_b_sat;

    // Stage C registers.
    logic        r_c_vld;
    logic        r_c_sens;
    logic [11:0] r_c_mv;
    logic [15:0] r_c_temp;
    logic [13:0] r_c_hum;
    logic [17:0] r_c_pres;
    logic [6:0]  r_c_q50;
    logic [6:0]  r_c_pct;
    t_div        r_c_div;
    t_sat        r_c_sat;

    // Stage A logic: scale the supply sample and the climate readings.
    logic [23:0] mv_prod;
    logic [15:0] t_mag;
    logic [22:0] t_prod;
    logic [21:0] h_prod;
    logic [25:0] p_prod;
    logic [11:0] n_a_mv;

    always_comb begin
        mv_prod = {12'd0, i_supply_sample[11:0]} * 24'd3600;
        n_a_mv  = i_supply_sample[12] ? 12'd0 : mv_prod[23:12];
        t_mag   = i_temperature_q8[15] ? (16'd0 - i_temperature_q8) : i_temperature_q8;
        t_prod  = {7'd0, t_mag} * 23'd100 + 23'd128;
        h_prod  = {7'd0, i_humidity_q8} * 22'd100 + 22'd128;
        p_prod  = {7'd0, i_pressure_q8} * 26'd100 + 26'd128;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_take;
        end
        r_a_sens <= i_sensor_valid;
        r_a_mv   <= n_a_mv;
        r_a_tneg <= i_temperature_q8[15];
        r_a_tmag <= t_prod[22:8];
        r_a_hum  <= h_prod[21:8];
        r_a_pres <= p_prod[25:8];
    end

    // Stage B logic: find the battery segment and form the rounded numerator.
    t_seg       seg;
    logic [3:0] seg_sel;
    t_seg       probe;
    logic [8:0] below;
    logic [11:0] n_b_num;
    t_sat       n_b_sat;

    always_comb begin
        seg_sel = '0;
        probe   = '0;
        for (int k = 0; k < SEG_COUNT; k++) begin
            probe = seg_entry(4'(k));
            if (r_a_mv <= probe.hi_mv && r_a_mv > probe.lo_mv) begin
                seg_sel = 4'(k);
            end
        end
        seg   = seg_entry(seg_sel);
        below = 9'(seg.hi_mv - r_a_mv);
        n_b_num = 12'({3'd0, below} * {8'd0, seg.pct_span}) + {4'd0, seg.half_span};
        priority if (r_a_mv >= BATT_TOP_MV) begin
            n_b_sat = SAT_FULL;
        end else if (r_a_mv <= BATT_BOT_MV) begin
            n_b_sat = SAT_ZERO;
        end else begin
            n_b_sat = SAT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_sens <= r_a_sens;
        r_b_mv   <= r_a_mv;
        r_b_temp <= r_a_tneg ? (16'd0 - {1'b0, r_a_tmag}) : {1'b0, r_a_tmag};
        r_b_hum  <= r_a_hum;
        r_b_pres <= r_a_pres;
        r_b_num  <= n_b_num;
        r_b_pct  <= seg.hi_pct;
        r_b_div  <= seg.div;
        r_b_sat  <= n_b_sat;
    end

    // Stage C logic: divide the numerator by 50 through a reciprocal.
    logic [22:0] q50_prod;

    always_comb begin
        q50_prod = {11'd0, r_b_num} * 23'd1311;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_sens <= r_b_sens;
        r_c_mv   <= r_b_mv;
        r_c_temp <= r_b_temp;
        r_c_hum  <= r_b_hum;
        r_c_pres <= r_b_pres;
        r_c_q50  <= q50_prod[22:16];
        r_c_pct  <= r_b_pct;
        r_c_div  <= r_b_div;
        r_c_sat  <= r_b_sat;
    end

    // Finish the division by the segment factor and build the record.
    logic [13:0] q3_prod;
    logic [6:0]  quot;
    logic [6:0]  batt;

    always_comb begin
        q3_prod = {7'd0, r_c_q50} * 14'd43;
        unique case (r_c_div)
            DIV_1:   quot = r_c_q50;
            DIV_2:   quot = {1'b0, r_c_q50[6:1]};
            DIV_3:   quot = {1'b0, q3_prod[12:7]};
            DIV_4:   quot = {2'b0, r_c_q50[6:2]};
            DIV_8:   quot = {3'b0, r_c_q50[6:3]};
            default: quot = r_c_q50;
        endcase
        unique case (r_c_sat)
            SAT_FULL: batt = PCT_FULL;
            SAT_ZERO: batt = 7'd0;
            SAT_NONE: batt = r_c_pct - quot;
            default:  batt = 7'd0;
        endcase
        o_wr_rec.sensor_valid = r_c_sens;
        o_wr_rec.batt         = batt;
        o_wr_rec.mv           = r_c_mv;
        o_wr_rec.temp         = r_c_temp;
        o_wr_rec.hum          = {2'b0, r_c_hum};
        o_wr_rec.pres         = {6'b0, r_c_pres};
    end

    assign o_wr_en    = r_c_vld;
    assign o_inflight = 2'({1'b0, r_a_vld} + {1'b0, r_b_vld} + {1'b0, r_c_vld});

endmodule

// ===== hw/rtl/bspe_queue.sv =====
// Short record queue between the front and back parts.
module bspe_queue
    import bspe_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  t_rec                       i_wr_rec,
    input  logic                       i_rd_en,
    output t_rec                       o_rd_rec,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wptr;
    logic [AW-1:0] n_rptr;

    // Pointer advance with wrap at the queue depth.
    always_comb begin
        n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wptr] <= i_wr_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr_en) begin
                r_wptr <= n_wptr;
            end
            if (i_rd_en) begin
                r_rptr <= n_rptr;
            end
            r_count <= r_count + CW'(i_wr_en) - CW'(i_rd_en);
        end
    end

    assign o_rd_rec = r_mem[r_rptr];
    assign o_empty  = (r_count == '0);
    assign o_count  = r_count;

endmodule

// ===== hw/rtl/bspe_back.sv =====
// Back part: serializes one record into payload bytes behind an output register.
module bspe_back
    import bspe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_rec       i_rd_rec,
    input  logic       i_q_empty,
    output logic       o_rd_en,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_payload_byte,
    output logic       o_last_byte
);

    t_rec             r_rec;
    logic             r_cur_vld;
    logic [POS_W-1:0] r_pos;
    logic             r_out_vld;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic [POS_W-1:0] n_pos;
    logic             out_adv;
    logic             at_last;

    // Advance when a record is loaded and the output register has room.
    always_comb begin
        out_adv = r_cur_vld && (!r_out_vld || i_pop);
        at_last = (r_pos == POS_LAST);
        o_rd_en = !i_q_empty && (!r_cur_vld || (out_adv && at_last));
        priority if (r_pos == POS_BATT && !r_rec.sensor_valid) begin
            n_pos = POS_VOLT_ID;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Current record and byte position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_pos     <= '0;
        end else begin
            if (o_rd_en) begin
                r_cur_vld <= 1'b1;
                r_pos     <= '0;
            end else if (out_adv) begin
                if (at_last) begin
                    r_cur_vld <= 1'b0;
                    r_pos     <= '0;
                end else begin
                    r_pos <= n_pos;
                end
            end
        end
        if (o_rd_en) begin
            r_rec <= i_rd_rec;
        end
    end

    // Output register holding the oldest undelivered byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
        if (out_adv) begin
            r_out_byte <= payload_at(r_rec, r_pos);
            r_out_last <= at_last;
        end
    end

    assign o_empty        = !r_out_vld;
    assign o_payload_byte = r_out_byte;
    assign o_last_byte    = r_out_last;

endmodule

// ===== hw/rtl/bthome_sensor_payload_encoder_unit.sv =====
// Each accepted reading yields one service-data payload: 18 bytes when sensor_valid is set,
// 8 bytes otherwise, one byte per cycle on the result side as long as pop is held and a
// record is ready, with last_byte on the final one. A reading passes the conversion
// pipeline stages A, B and C before it reaches the record queue. The byte serializer loads
// the next queued record as the final byte of the current one moves to its output register.
// The input side takes readings as long as the queue plus the pipeline have room for
// QUEUE_DEPTH records, so it keeps taking them while the result side stalls, until full.
module bthome_sensor_payload_encoder_unit
    import bspe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [12:0] i_supply_sample,
    input  logic               i_sensor_valid,
    input  logic signed [15:0] i_temperature_q8,
    input  logic        [14:0] i_humidity_q8,
    input  logic        [18:0] i_pressure_q8,
    output logic               empty,
    input  logic               pop,
    output logic        [7:0]  o_payload_byte,
    output logic               o_last_byte
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic          take;
    logic          wr_en;
    t_rec          wr_rec;
    logic [1:0]    inflight;
    logic          rd_en;
    t_rec          rd_rec;
    logic          q_empty;
    logic [CW-1:0] q_count;
    logic [CW:0]   reserved;

    // Records queued plus those still in the pipeline must fit the queue.
    always_comb begin
        reserved = {1'b0, q_count} + (CW + 1)'(inflight);
        full     = (reserved >= (CW + 1)'(QUEUE_DEPTH));
        take     = push && !full;
    end

    bspe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_supply_sample  (i_supply_sample),
        .i_sensor_valid   (i_sensor_valid),
        .i_temperature_q8 (i_temperature_q8),
        .i_humidity_q8    (i_humidity_q8),
        .i_pressure_q8    (i_pressure_q8),
        .o_wr_en          (wr_en),
        .o_wr_rec         (wr_rec),
        .o_inflight       (inflight)
    );

    bspe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_rec (wr_rec),
        .i_rd_en  (rd_en),
        .o_rd_rec (rd_rec),
        .o_empty  (q_empty),
        .o_count  (q_count)
    );

    bspe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd_rec       (rd_rec),
        .i_q_empty      (q_empty),
        .o_rd_en        (rd_en),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_payload_byte (o_payload_byte),
        .o_last_byte    (o_last_byte)
    );

endmodule

// ===== hw/rtl/bspe_checker.sv =====
// Port-level checker for the payload encoder, bound to the top level.
module bspe_checker
    import bspe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_payload_byte,
    input logic       o_last_byte
);

    logic [4:0] r_cnt;
    logic       deliver;

    assign deliver = pop && !empty;

    // Count bytes delivered within the current payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (deliver) begin
            r_cnt <= o_last_byte ? 5'd0 : r_cnt + 5'd1;
        end
    end

    // Nothing is offered or blocked right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("outputs not idle after reset");

    // Every payload opens with the service identifier byte.
    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (deliver && r_cnt == 5'd0) |-> (o_payload_byte == HDR_UUID_LO && !o_last_byte))
        else $error("payload does not start with the identifier");

    // A payload ends only after 8 or 18 bytes.
    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (deliver && o_last_byte) |-> (r_cnt == 5'd7 || r_cnt == 5'd17))
        else $error("payload length is wrong");

    // An offered byte holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_payload_byte) && $stable(o_last_byte)))
        else $error("offered byte changed before it was taken");

endmodule

bind bthome_sensor_payload_encoder_unit bspe_checker u_bspe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_payload_byte (o_payload_byte),
    .o_last_byte    (o_last_byte)
);
